// File: rtl/core/swb_pkg.sv
// Shared types, constants and register indexes of the similarity warp block.
package swb_pkg;

    localparam int MaxSrcWidthDef  = 256;
    localparam int MaxSrcHeightDef = 256;

    localparam int CoefW  = 20;
    localparam int ShiftW = 26;
    localparam int SizeW  = 9;
    localparam int PixW   = 8;
    localparam int PosW   = 8;
    localparam int CfgIdxW = 3;
    localparam int CfgDatW = 32;

    // Source position in Q.16: 8-bit position times Q4.16 plus Q10.16 fits in 30 bits.
    localparam int PosQW = 30;

    localparam logic [CoefW-1:0]  ScaleCosRst = CoefW'(65536);
    localparam logic [SizeW-1:0]  SizeRst     = SizeW'(256);

    typedef enum logic [CfgIdxW-1:0] {
        REG_SCALE_COS  = 3'd0,
        REG_SCALE_SIN  = 3'd1,
        REG_SHIFT_X    = 3'd2,
        REG_SHIFT_Y    = 3'd3,
        REG_SRC_WIDTH  = 3'd4,
        REG_SRC_HEIGHT = 3'd5,
        REG_OUT_WIDTH  = 3'd6,
        REG_OUT_HEIGHT = 3'd7
    } t_reg_idx;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_opcode;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic signed [CoefW-1:0]  scale_cos;
        logic signed [CoefW-1:0]  scale_sin;
        logic signed [ShiftW-1:0] shift_x;
        logic signed [ShiftW-1:0] shift_y;
        logic [SizeW-1:0]         src_width;
        logic [SizeW-1:0]         src_height;
        logic [SizeW-1:0]         out_width;
        logic [SizeW-1:0]         out_height;
    } t_cfg;

endpackage

// File: rtl/core/swb_cfg.sv
// Configuration register file of the similarity warp block.
module swb_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [swb_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [swb_pkg::CfgDatW-1:0]   i_cfg_data,
    output swb_pkg::t_cfg                 o_cfg
);
    import swb_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    // Register writes, one per transaction.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_cos  <= ScaleCosRst;
            r_cfg.scale_sin  <= '0;
            r_cfg.shift_x    <= '0;
            r_cfg.shift_y    <= '0;
            r_cfg.src_width  <= SizeRst;
            r_cfg.src_height <= SizeRst;
            r_cfg.out_width  <= SizeRst;
            r_cfg.out_height <= SizeRst;
        end else if (i_cfg_valid) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_SCALE_COS:  r_cfg.scale_cos  <= i_cfg_data[CoefW-1:0];
                REG_SCALE_SIN:  r_cfg.scale_sin  <= i_cfg_data[CoefW-1:0];
                REG_SHIFT_X:    r_cfg.shift_x    <= i_cfg_data[ShiftW-1:0];
                REG_SHIFT_Y:    r_cfg.shift_y    <= i_cfg_data[ShiftW-1:0];
                REG_SRC_WIDTH:  r_cfg.src_width  <= i_cfg_data[SizeW-1:0];
                REG_SRC_HEIGHT: r_cfg.src_height <= i_cfg_data[SizeW-1:0];
                REG_OUT_WIDTH:  r_cfg.out_width  <= i_cfg_data[SizeW-1:0];
                REG_OUT_HEIGHT: r_cfg.out_height <= i_cfg_data[SizeW-1:0];
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/core/swb_coord.sv
// Coordinate pipeline: maps an output position to a source neighborhood.
module swb_coord #(
    parameter int MAX_SRC_WIDTH  = swb_pkg::MaxSrcWidthDef,
    parameter int MAX_SRC_HEIGHT = swb_pkg::MaxSrcHeightDef,
    localparam int XW = $clog2(MAX_SRC_WIDTH),
    localparam int YW = $clog2(MAX_SRC_HEIGHT)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  swb_pkg::t_cfg              i_cfg,
    input  logic                       i_valid,
    input  logic [swb_pkg::PosW-1:0]   i_col,
    input  logic [swb_pkg::PosW-1:0]   i_row,
    output logic                       o_valid,
    output logic                       o_outside,
    output logic                       o_last,
    output logic [XW-1:0]              o_ix,
    output logic [YW-1:0]              o_iy,
    output logic [7:0]                 o_u,
    output logic [7:0]                 o_v
);
    import swb_pkg::*;

    localparam int ProdW = CoefW + PosW + 1;
    localparam int IntW  = PosQW - 16;
    localparam logic [SizeW-1:0] MaxW = SizeW'(MAX_SRC_WIDTH > 256 ? 256 : MAX_SRC_WIDTH);
    localparam logic [SizeW-1:0] MaxH = SizeW'(MAX_SRC_HEIGHT > 256 ? 256 : MAX_SRC_HEIGHT);

    logic signed [ProdW-1:0] r_ac, r_br, r_ar, r_bc;
    logic                    r_v1, r_last1;
    logic signed [PosQW-1:0] n_x, n_y, r_x, r_y;
    logic                    r_v2, r_last2;
    logic [IntW-1:0]         w_ix, w_iy;
    logic [SizeW-1:0]        w_w, w_h;
    logic                    w_out;

    // Stage 1: four products of coefficient and position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
        end
        r_ac <= ProdW'(i_cfg.scale_cos * $signed({1'b0, i_col}));
        r_br <= ProdW'(i_cfg.scale_sin * $signed({1'b0, i_row}));
        r_ar <= ProdW'(i_cfg.scale_cos * $signed({1'b0, i_row}));
        r_bc <= ProdW'(i_cfg.scale_sin * $signed({1'b0, i_col}));
        r_last1 <= (SizeW'(i_col) + 1'b1 == i_cfg.out_width)
                && (SizeW'(i_row) + 1'b1 == i_cfg.out_height);
    end

    // Stage 2: sums with the translation.
    assign n_x = PosQW'(r_ac) - PosQW'(r_br) + PosQW'(i_cfg.shift_x);
    assign n_y = PosQW'(r_ar) + PosQW'(r_bc) + PosQW'(i_cfg.shift_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_x     <= n_x;
        r_y     <= n_y;
        r_last2 <= r_last1;
    end

    // Stage 3: range check and split into integer and fraction.
    assign w_ix = r_x[PosQW-1:16];
    assign w_iy = r_y[PosQW-1:16];
    assign w_w  = (i_cfg.src_width  < MaxW) ? i_cfg.src_width  : MaxW;
    assign w_h  = (i_cfg.src_height < MaxH) ? i_cfg.src_height : MaxH;
    assign w_out = r_x[PosQW-1] || r_y[PosQW-1]
                || ({1'b0, w_ix} + 1'b1 >= (IntW+1)'(w_w))
                || ({1'b0, w_iy} + 1'b1 >= (IntW+1)'(w_h));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_v2;
        end
        o_outside <= w_out;
        o_last    <= r_last2;
        o_ix      <= w_ix[XW-1:0];
        o_iy      <= w_iy[YW-1:0];
        o_u       <= r_x[15:8];
        o_v       <= r_y[15:8];
    end

endmodule

// File: rtl/core/swb_mem.sv
// Source image store in four row and column parity banks.
module swb_mem #(
    parameter int MAX_SRC_WIDTH  = swb_pkg::MaxSrcWidthDef,
    parameter int MAX_SRC_HEIGHT = swb_pkg::MaxSrcHeightDef,
    localparam int XW = $clog2(MAX_SRC_WIDTH),
    localparam int YW = $clog2(MAX_SRC_HEIGHT)
) (
    input  logic                      i_clk,
    input  logic                      i_wr_en,
    input  logic [XW-1:0]             i_wr_x,
    input  logic [YW-1:0]             i_wr_y,
    input  logic [swb_pkg::PixW-1:0]  i_wr_data,
    input  logic [XW-1:0]             i_rd_x,
    input  logic [YW-1:0]             i_rd_y,
    output logic [swb_pkg::PixW-1:0]  o_p00,
    output logic [swb_pkg::PixW-1:0]  o_p01,
    output logic [swb_pkg::PixW-1:0]  o_p10,
    output logic [swb_pkg::PixW-1:0]  o_p11
);
    import swb_pkg::*;

    localparam int HXW = (XW > 1) ? XW - 1 : 1;
    localparam int HYW = (YW > 1) ? YW - 1 : 1;
    localparam int AW = HXW + HYW;
    // The bank address is the concatenation of the half row and half column.
    localparam int BankD = 1 << AW;

    logic [PixW-1:0] mem0 [BankD];
    logic [PixW-1:0] mem1 [BankD];
    logic [PixW-1:0] mem2 [BankD];
    logic [PixW-1:0] mem3 [BankD];

    logic [XW-1:0] w_x1;
    logic [YW-1:0] w_y1;
    logic [HXW-1:0] w_ex, w_ox;
    logic [HYW-1:0] w_ey, w_oy;
    logic [AW-1:0]  w_wa;
    logic [1:0]     w_wb;
    logic           r_px, r_py;
    logic [PixW-1:0] r_b0, r_b1, r_b2, r_b3;

    // Each bank holds one column parity and one row parity.
    assign w_x1 = i_rd_x + 1'b1;
    assign w_y1 = i_rd_y + 1'b1;
    assign w_ex = i_rd_x[0] ? HXW'(w_x1 >> 1) : HXW'(i_rd_x >> 1);
    assign w_ox = HXW'(i_rd_x >> 1);
    assign w_ey = i_rd_y[0] ? HYW'(w_y1 >> 1) : HYW'(i_rd_y >> 1);
    assign w_oy = HYW'(i_rd_y >> 1);
    assign w_wa = {HYW'(i_wr_y >> 1), HXW'(i_wr_x >> 1)};
    assign w_wb = {i_wr_y[0], i_wr_x[0]};

    // Writes go to one bank; every bank is read each cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en && w_wb == 2'd0) mem0[w_wa] <= i_wr_data;
        if (i_wr_en && w_wb == 2'd1) mem1[w_wa] <= i_wr_data;
        if (i_wr_en && w_wb == 2'd2) mem2[w_wa] <= i_wr_data;
        if (i_wr_en && w_wb == 2'd3) mem3[w_wa] <= i_wr_data;
        r_b0 <= mem0[{w_ey, w_ex}];
        r_b1 <= mem1[{w_ey, w_ox}];
        r_b2 <= mem2[{w_oy, w_ex}];
        r_b3 <= mem3[{w_oy, w_ox}];
        r_px <= i_rd_x[0];
        r_py <= i_rd_y[0];
    end

    // Route banks back to neighbor positions by the read parity.
    always_comb begin
        case ({r_py, r_px})
            2'b00: begin o_p00 = r_b0; o_p01 = r_b1; o_p10 = r_b2; o_p11 = r_b3; end
            2'b01: begin o_p00 = r_b1; o_p01 = r_b0; o_p10 = r_b3; o_p11 = r_b2; end
            2'b10: begin o_p00 = r_b2; o_p01 = r_b3; o_p10 = r_b0; o_p11 = r_b1; end
            default: begin o_p00 = r_b3; o_p01 = r_b2; o_p10 = r_b1; o_p11 = r_b0; end
        endcase
    end

endmodule

// File: rtl/core/swb_blend.sv
// Bilinear blend pipeline with round to nearest.
module swb_blend (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic                      i_outside,
    input  logic                      i_last,
    input  logic [7:0]                i_u,
    input  logic [7:0]                i_v,
    input  logic [swb_pkg::PixW-1:0]  i_p00,
    input  logic [swb_pkg::PixW-1:0]  i_p01,
    input  logic [swb_pkg::PixW-1:0]  i_p10,
    input  logic [swb_pkg::PixW-1:0]  i_p11,
    output logic                      o_valid,
    output logic [swb_pkg::PixW-1:0]  o_pixel,
    output logic                      o_outside,
    output logic                      o_last
);
    import swb_pkg::*;

    logic [8:0]  w_nu, w_nv;
    logic [16:0] r_t, r_b;
    logic [8:0]  r_v;
    logic        r_val, r_out, r_last;
    logic [25:0] w_acc;

    assign w_nu = 9'd256 - {1'b0, i_u};
    assign w_nv = 9'd256 - {1'b0, r_v[7:0]};

    // Stage 1: horizontal blend of the top and bottom pairs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_val <= 1'b0;
        end else begin
            r_val <= i_valid;
        end
        r_t    <= 17'(w_nu * i_p00) + 17'({1'b0, i_u} * i_p01);
        r_b    <= 17'(w_nu * i_p10) + 17'({1'b0, i_u} * i_p11);
        r_v    <= {1'b0, i_v};
        r_out  <= i_outside;
        r_last <= i_last;
    end

    // Stage 2: vertical blend and rounding.
    assign w_acc = 26'(w_nv * r_t) + 26'(r_v * r_b) + 26'd32768;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_val;
        end
        o_pixel   <= r_out ? '0 : w_acc[23:16];
        o_outside <= r_out;
        o_last    <= r_last;
    end

endmodule

// File: rtl/core/similarity_warp_bilinear.sv
// Top level of the similarity warp block with bilinear sampling.
//
//  channel  | handshake                      | payload
//  command  | i_start, o_busy                | i_opcode, i_pos_col, i_pos_row, i_write_value
//  result   | o_valid (one cycle, no stall)  | o_out_pixel, o_outside, o_frame_last
//  config   | i_cfg_valid, o_cfg_ready       | i_cfg_index, i_cfg_data
//
// One transaction is taken every cycle; o_busy is always low.
// A sample passes a multiply stage, a sum stage, one check stage, one read of the
// four parity banks and two blend stages before its result appears.
// A write is registered in r_wr_en and then in r_wm_en before it reaches the banks,
// so a sample accepted just before it still reads the old contents. A write yields no result.
// Reset clears the pipeline valids and the registers; image contents stay undefined.
module similarity_warp_bilinear #(
    parameter int MAX_SRC_WIDTH  = swb_pkg::MaxSrcWidthDef,
    parameter int MAX_SRC_HEIGHT = swb_pkg::MaxSrcHeightDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_opcode,
    input  logic [swb_pkg::PosW-1:0]      i_pos_col,
    input  logic [swb_pkg::PosW-1:0]      i_pos_row,
    input  logic [swb_pkg::PixW-1:0]      i_write_value,
    output logic                          o_valid,
    output logic [swb_pkg::PixW-1:0]      o_out_pixel,
    output logic                          o_outside,
    output logic                          o_frame_last,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [swb_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [swb_pkg::CfgDatW-1:0]   i_cfg_data
);
    import swb_pkg::*;

    localparam int XW = $clog2(MAX_SRC_WIDTH);
    localparam int YW = $clog2(MAX_SRC_HEIGHT);

    t_cfg w_cfg;
    logic w_acc, w_smp;
    logic r_wr_en;
    logic [XW-1:0] r_wr_x;
    logic [YW-1:0] r_wr_y;
    logic [PixW-1:0] r_wr_d;
    logic r_wm_en;
    logic [XW-1:0] r_wm_x;
    logic [YW-1:0] r_wm_y;
    logic [PixW-1:0] r_wm_d;
    logic c_valid, c_out, c_last;
    logic [XW-1:0] c_ix;
    logic [YW-1:0] c_iy;
    logic [7:0] c_u, c_v;
    logic r_m_val, r_m_out, r_m_last;
    logic [7:0] r_m_u, r_m_v;
    logic [PixW-1:0] p00, p01, p10, p11;

    assign o_busy = 1'b0;
    assign w_acc  = i_start && !o_busy;
    assign w_smp  = w_acc && (t_opcode'(i_opcode) == OP_SAMPLE);

    swb_cfg u_cfg (
        .i_clk, .i_rst_n, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_index, .i_cfg_data, .o_cfg(w_cfg)
    );

    // Register a write; positions beyond the store are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_en <= 1'b0;
        end else begin
            r_wr_en <= w_acc && (t_opcode'(i_opcode) == OP_WRITE)
                    && (32'(i_pos_col) < MAX_SRC_WIDTH)
                    && (32'(i_pos_row) < MAX_SRC_HEIGHT);
        end
        r_wr_x <= XW'(i_pos_col);
        r_wr_y <= YW'(i_pos_row);
        r_wr_d <= i_write_value;
    end

    // Register the write a second time so that a sample accepted in the cycle
    // before it reads the banks no later than the write lands.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wm_en <= 1'b0;
        end else begin
            r_wm_en <= r_wr_en;
        end
        r_wm_x <= r_wr_x;
        r_wm_y <= r_wr_y;
        r_wm_d <= r_wr_d;
    end

    swb_coord #(.MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)) u_coord (
        .i_clk, .i_rst_n, .i_cfg(w_cfg), .i_valid(w_smp),
        .i_col(i_pos_col), .i_row(i_pos_row),
        .o_valid(c_valid), .o_outside(c_out), .o_last(c_last),
        .o_ix(c_ix), .o_iy(c_iy), .o_u(c_u), .o_v(c_v)
    );

    swb_mem #(.MAX_SRC_WIDTH(MAX_SRC_WIDTH), .MAX_SRC_HEIGHT(MAX_SRC_HEIGHT)) u_mem (
        .i_clk, .i_wr_en(r_wm_en), .i_wr_x(r_wm_x), .i_wr_y(r_wm_y), .i_wr_data(r_wm_d),
        .i_rd_x(c_ix), .i_rd_y(c_iy),
        .o_p00(p00), .o_p01(p01), .o_p10(p10), .o_p11(p11)
    );

    // Side data kept in step with the bank read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_val <= 1'b0;
        end else begin
            r_m_val <= c_valid;
        end
        r_m_out  <= c_out;
        r_m_last <= c_last;
        r_m_u    <= c_u;
        r_m_v    <= c_v;
    end

    swb_blend u_blend (
        .i_clk, .i_rst_n, .i_valid(r_m_val), .i_outside(r_m_out), .i_last(r_m_last),
        .i_u(r_m_u), .i_v(r_m_v), .i_p00(p00), .i_p01(p01), .i_p10(p10), .i_p11(p11),
        .o_valid, .o_pixel(o_out_pixel), .o_outside, .o_last(o_frame_last)
    );

    // Every accepted sample leaves the pipe with o_valid.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_smp |-> ##6 o_valid) else $error("sample result missing");
    // No result without an earlier accepted sample.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_smp, 6)) else $error("result without sample");
    // Outside results carry a zero pixel.
    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_outside) |-> (o_out_pixel == '0)) else $error("outside pixel not zero");

endmodule
